[rtl/core/kxb_pkg.sv]
// shared types, constants and the base64 alphabet for the keyed xor base64 encoder
package kxb_pkg;

    localparam int MAX_KEY_BYTES = 8;
    localparam int KEY_IDX_W     = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KEY_LEN_W     = 4;
    localparam int KEY_W         = 64;
    localparam int CHAR_W        = 7;
    localparam int MAX_CHARS     = 4;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3d;

    typedef enum logic [0:0] {
        CFG_KEY_BYTES  = 1'b0,
        CFG_KEY_LENGTH = 1'b1
    } cfg_idx_t;

    typedef logic [CHAR_W-1:0] char_t;

    typedef struct packed {
        logic                      last;
        logic [1:0]                cnt_m1;
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
    } entry_t;

    function automatic char_t b64_char(input logic [5:0] v);
        char_t c;
        c = 7'({1'b0, v});
        if (v < 6'd26)
        begin
            b64_char = c + 7'd65;
        end
        else if (v < 6'd52)
        begin
            b64_char = c + 7'd71;
        end
        else if (v < 6'd62)
        begin
            b64_char = c - 7'd4;
        end
        else if (v == 6'd62)
        begin
            b64_char = 7'h2b;
        end
        else
        begin
            b64_char = 7'h2f;
        end
    endfunction

endpackage

[rtl/core/kxb_front.sv]
// front end: config registers, key and position xor, group tracking, char group build
module kxb_front
    import kxb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [0:0]        cfg_index,
    input  logic [KEY_W-1:0]  cfg_data,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              in_last,
    output entry_t            entry
);

    logic [KEY_W-1:0]     key_reg;
    logic [KEY_LEN_W-1:0] klen_reg;
    logic [7:0]           pos_reg;
    logic [7:0]           pos_next;
    logic [KEY_IDX_W-1:0] kidx_reg;
    logic [KEY_IDX_W-1:0] kidx_next;
    logic [1:0]           phase_reg;
    logic [1:0]           phase_next;
    logic [3:0]           left_reg;
    logic [3:0]           left_next;

    logic [KEY_LEN_W-1:0] len;
    logic [KEY_LEN_W-1:0] kidx_inc;
    logic [7:0]           kb;
    logic [7:0]           b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            klen_reg <= KEY_LEN_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_KEY_BYTES:  key_reg  <= cfg_data;
                CFG_KEY_LENGTH: klen_reg <= cfg_data[KEY_LEN_W-1:0];
                default:        key_reg  <= key_reg;
            endcase
        end
    end

    always_comb
    begin
        if (klen_reg == '0)
        begin
            len = KEY_LEN_W'(1);
        end
        else if (klen_reg > KEY_LEN_W'(MAX_KEY_BYTES))
        begin
            len = KEY_LEN_W'(MAX_KEY_BYTES);
        end
        else
        begin
            len = klen_reg;
        end
        kidx_inc = KEY_LEN_W'(kidx_reg) + KEY_LEN_W'(1);
        kb       = key_reg[{kidx_reg, 3'b000} +: 8];
        b        = data_byte ^ kb ^ pos_reg;
    end

    always_comb
    begin
        entry.last   = 1'b0;
        entry.cnt_m1 = 2'd0;
        entry.chars  = {MAX_CHARS{PAD_CHAR}};
        phase_next   = phase_reg;
        left_next    = left_reg;
        unique case (phase_reg)
            2'd1:
            begin
                entry.chars[0] = b64_char({left_reg[1:0], b[7:4]});
                left_next      = b[3:0];
                phase_next     = 2'd2;
                if (in_last)
                begin
                    entry.chars[1] = b64_char({b[3:0], 2'b00});
                    entry.cnt_m1   = 2'd2;
                    entry.last     = 1'b1;
                end
            end
            2'd2:
            begin
                entry.chars[0] = b64_char({left_reg, b[7:6]});
                entry.chars[1] = b64_char(b[5:0]);
                entry.cnt_m1   = 2'd1;
                entry.last     = in_last;
                left_next      = 4'd0;
                phase_next     = 2'd0;
            end
            default:
            begin
                entry.chars[0] = b64_char(b[7:2]);
                left_next      = {2'b00, b[1:0]};
                phase_next     = 2'd1;
                if (in_last)
                begin
                    entry.chars[1] = b64_char({b[1:0], 4'b0000});
                    entry.cnt_m1   = 2'd3;
                    entry.last     = 1'b1;
                end
            end
        endcase
        pos_next  = pos_reg + 8'd1;
        kidx_next = (kidx_inc >= len) ? '0 : kidx_inc[KEY_IDX_W-1:0];
        if (in_last)
        begin
            pos_next   = 8'd0;
            kidx_next  = '0;
            phase_next = 2'd0;
            left_next  = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            kidx_reg  <= '0;
            phase_reg <= '0;
            left_reg  <= '0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            kidx_reg  <= kidx_next;
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("group phase left its range");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |=> pos_reg == 8'd0 && kidx_reg == '0 && phase_reg == 2'd0)
        else $error("message end did not clear the state");

    a_kidx_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !in_last && (kidx_inc >= len) |=> kidx_reg == '0)
        else $error("key index did not wrap");

endmodule

[rtl/core/kxb_queue.sv]
// small flop queue of char groups between front and back
module kxb_queue
    import kxb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   nempty,
    output entry_t pop_data
);

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg;
    logic [QPTR_W-1:0]   wptr_next;
    logic [QPTR_W-1:0]   rptr_reg;
    logic [QPTR_W-1:0]   rptr_next;
    logic [QCNT_W-1:0]   cnt_reg;
    logic [QCNT_W-1:0]   cnt_next;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign nempty   = (cnt_reg != '0);
    assign pop_data = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nempty)
        else $error("pop from empty queue");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

[rtl/core/kxb_back.sv]
// back end: serializes each char group into one output beat per char
module kxb_back
    import kxb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   q_nempty,
    input  entry_t q_data,
    output logic   q_pop,
    output logic   out_valid,
    input  logic   out_ready,
    output char_t  out_char,
    output logic   out_last
);

    entry_t     cur_reg;
    logic       cur_valid_reg;
    logic       cur_valid_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       ov_reg;
    logic       ov_next;
    char_t      oc_reg;
    logic       ol_reg;

    logic       adv;
    logic       emit;
    logic       done;

    always_comb
    begin
        adv            = !ov_reg || out_ready;
        emit           = adv && cur_valid_reg;
        done           = emit && (idx_reg == cur_reg.cnt_m1);
        q_pop          = q_nempty && (!cur_valid_reg || done);
        cur_valid_next = q_pop ? 1'b1 : (done ? 1'b0 : cur_valid_reg);
        idx_next       = q_pop ? 2'd0 : (emit ? idx_reg + 2'd1 : idx_reg);
        ov_next        = emit ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        if (emit)
        begin
            oc_reg <= cur_reg.chars[idx_reg];
            ol_reg <= done && cur_reg.last;
        end
    end

    assign out_valid = ov_reg;
    assign out_char  = oc_reg;
    assign out_last  = ol_reg;

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> idx_reg <= cur_reg.cnt_m1)
        else $error("char index past group end");

    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !cur_valid_reg || done)
        else $error("group loaded over a busy one");

    a_done_retires: assert property (@(posedge clk) disable iff (!rst_n)
        done && !q_pop |=> !cur_valid_reg)
        else $error("finished group not retired");

endmodule

[rtl/core/keyed_xor_base64_encoder.sv]
// top level of the keyed xor base64 encoder
//
//   channel  signals                                   dir   beat
//   cfg      cfg_valid cfg_ready cfg_index cfg_data   in    one register write
//   in       in_valid in_ready data_byte in_last      in    one message byte
//   out      out_valid out_ready out_char out_last    out   one ascii char
//
// the front takes a byte in every cycle while the four-entry group queue has room
// the back emits one char per cycle while out is not stalled: one or two per byte, up to four on a last byte
// sustained rate is set by the output serializer, four chars per three bytes
// reset clears position, key index, group state, queue and output valid
// a stall on out backs up through the queue and then drops in_ready
module keyed_xor_base64_encoder
    import kxb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [KEY_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              in_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] out_char,
    output logic              out_last
);

    entry_t entry;
    entry_t q_data;
    logic   q_full;
    logic   q_nempty;
    logic   q_pop;
    logic   accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && !q_full;

    kxb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .data_byte (data_byte),
        .in_last   (in_last),
        .entry     (entry)
    );

    kxb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (entry),
        .full      (q_full),
        .pop       (q_pop),
        .nempty    (q_nempty),
        .pop_data  (q_data)
    );

    kxb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_nempty  (q_nempty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .out_last  (out_last)
    );

endmodule

[sim/keyed_xor_base64_encoder_tb.sv]
// self-checking testbench for the keyed xor base64 encoder
`timescale 1ns / 1ps

module keyed_xor_base64_encoder_tb;
    import kxb_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } enc_char_t;

    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int SETTLE_CYCLES = 8;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [0:0]        cfg_index;
    logic [KEY_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        data_byte;
    logic              in_last;
    logic              out_valid;
    logic              out_ready;
    logic [CHAR_W-1:0] out_char;
    logic              out_last;

    // predictor state and register copies
    logic [KEY_W-1:0]     key_bytes_cfg;
    logic [KEY_LEN_W-1:0] key_len_cfg;
    logic [7:0]           enc_pos;
    logic [2:0]           enc_key_idx;
    logic [1:0]           enc_phase;
    logic [3:0]           enc_carry;

    enc_char_t expected_chars[$];

    int  mismatches;
    int  n_bytes;
    int  n_msgs;
    int  n_chars;
    int  n_cfg;
    int  hold_cycles;
    int  rx_wait;
    bit  tx_idle_en;
    bit  rx_idle_en;

    keyed_xor_base64_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .out_last  (out_last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    endtask

    function automatic logic [CHAR_W-1:0] b64_symbol(input logic [5:0] v);
        logic [7:0] c;
        c = ALPHABET[8*(63-int'(v)) +: 8];
        return c[CHAR_W-1:0];
    endfunction

    task automatic expect_char(input logic [CHAR_W-1:0] ch, input logic last);
        enc_char_t e;
        e.ch   = ch;
        e.last = last;
        expected_chars.push_back(e);
    endtask

    task automatic predict_chars(input logic [7:0] raw, input logic last);
        int         len;
        int         kidx;
        logic [7:0] x;
        len = int'(key_len_cfg);
        if (len == 0)
            len = 1;
        if (len > MAX_KEY_BYTES)
            len = MAX_KEY_BYTES;
        kidx = int'(enc_key_idx);
        x = raw ^ key_bytes_cfg[8*kidx +: 8] ^ enc_pos;
        enc_pos = enc_pos + 8'd1;
        enc_key_idx = (kidx + 1 >= len) ? 3'd0 : 3'(kidx + 1);
        if (enc_phase == 2'd1)
        begin
            expect_char(b64_symbol({enc_carry[1:0], x[7:4]}), 1'b0);
            enc_carry = x[3:0];
            enc_phase = 2'd2;
            if (last)
            begin
                expect_char(b64_symbol({x[3:0], 2'b00}), 1'b0);
                expect_char(PAD_CHAR, 1'b1);
            end
        end
        else if (enc_phase == 2'd2)
        begin
            expect_char(b64_symbol({enc_carry, x[7:6]}), 1'b0);
            expect_char(b64_symbol(x[5:0]), last);
            enc_carry = 4'd0;
            enc_phase = 2'd0;
        end
        else
        begin
            expect_char(b64_symbol(x[7:2]), 1'b0);
            enc_carry = {2'b00, x[1:0]};
            enc_phase = 2'd1;
            if (last)
            begin
                expect_char(b64_symbol({x[1:0], 4'b0000}), 1'b0);
                expect_char(PAD_CHAR, 1'b0);
                expect_char(PAD_CHAR, 1'b1);
            end
        end
        if (last)
        begin
            enc_pos     = 8'd0;
            enc_key_idx = 3'd0;
            enc_phase   = 2'd0;
            enc_carry   = 4'd0;
        end
    endtask

    // receiver: long hold-offs first, then per-char stalls
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready = 1'b0;
                hold_cycles--;
            end
            else if (rx_wait > 0)
            begin
                out_ready = 1'b0;
                rx_wait--;
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_chars
        enc_char_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_chars++;
            if (expected_chars.size() == 0)
            begin
                report_mismatch("unexpected char beat", int'(out_char), 0);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (out_char !== want.ch)
                    report_mismatch("out_char", int'(out_char), int'(want.ch));
                if (out_last !== want.last)
                    report_mismatch("out_last", int'(out_last), int'(want.last));
            end
            rx_wait = rx_idle_en ? $urandom_range(0, 11) : 0;
        end
    end

    // all tasks below start and end just after a falling edge
    task automatic write_reg(input cfg_idx_t idx, input logic [KEY_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_KEY_BYTES)
            key_bytes_cfg = value;
        else
            key_len_cfg = value[KEY_LEN_W-1:0];
        n_cfg++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        data_byte = b;
        in_last   = last;
        do
            @(posedge clk);
        while (!in_ready);
        predict_chars(b, last);
        n_bytes++;
        if (last)
            n_msgs++;
        @(negedge clk);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    task automatic drain;
        in_valid = 1'b0;
        while (expected_chars.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic test_padding;
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'ha5, 1'b0);
        send_byte(8'h5a, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h7e, 1'b1);
        drain();
    endtask

    task automatic test_key_length_limits;
        write_reg(CFG_KEY_BYTES, {KEY_W{1'b1}});
        write_reg(CFG_KEY_LENGTH, {{(KEY_W-KEY_LEN_W){1'b1}}, 4'd0});
        send_byte(8'h3c, 1'b0);
        send_byte(8'hc3, 1'b1);
        drain();
        write_reg(CFG_KEY_BYTES, {$urandom, $urandom});
        write_reg(CFG_KEY_LENGTH, {{(KEY_W-KEY_LEN_W){1'b0}}, 4'd15});
        send_message(9);
        drain();
    endtask

    task automatic test_key_shrink;
        write_reg(CFG_KEY_LENGTH, KEY_W'(8));
        write_reg(CFG_KEY_BYTES, {$urandom, $urandom});
        for (int i = 0; i < 6; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        drain();
        write_reg(CFG_KEY_LENGTH, KEY_W'(3));
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        drain();
    endtask

    task automatic test_position_wrap;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        write_reg(CFG_KEY_LENGTH, KEY_W'($urandom_range(1, 8)));
        send_message(260);
        drain();
    endtask

    task automatic test_backpressure;
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b0;
        hold_cycles = 150;
        send_message(10);
        drain();
    endtask

    task automatic test_random;
        logic [KEY_LEN_W-1:0] len_val;
        logic [KEY_W-1:0]     key_val;
        int                   budget;
        int                   len;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin key_val = {KEY_W{1'b1}}; len_val = 4'd1; end
                1: begin key_val = '0; len_val = 4'd8; end
                2: begin key_val = {$urandom, $urandom}; len_val = 4'd0; end
                3: begin key_val = {$urandom, $urandom}; len_val = 4'd15; end
                default:
                begin
                    key_val = {$urandom, $urandom};
                    len_val = 4'($urandom_range(0, 15));
                end
            endcase
            write_reg(CFG_KEY_BYTES, key_val);
            write_reg(CFG_KEY_LENGTH, {$urandom, 28'($urandom), len_val});
            tx_idle_en = (ph % 4) != 1;
            rx_idle_en = (ph % 4) != 2;
            budget = 4;
            while (budget > 0)
            begin
                len = $urandom_range(1, 4);
                send_message(len);
                budget -= len;
            end
            drain();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_KEY_BYTES;
        cfg_data    = '0;
        in_valid    = 1'b0;
        data_byte   = 8'h00;
        in_last     = 1'b0;
        hold_cycles = 0;
        rx_wait     = 0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        mismatches  = 0;
        n_bytes     = 0;
        n_msgs      = 0;
        n_chars     = 0;
        n_cfg       = 0;
        key_bytes_cfg = '0;
        key_len_cfg   = 4'd1;
        enc_pos       = 8'd0;
        enc_key_idx   = 3'd0;
        enc_phase     = 2'd0;
        enc_carry     = 4'd0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_padding();
        test_key_length_limits();
        test_key_shrink();
        test_position_wrap();
        test_backpressure();
        test_random();

        drain();
        while (expected_chars.size() != 0)
        begin
            report_mismatch("missing char beat", 0, int'(expected_chars[0].ch));
            void'(expected_chars.pop_front());
        end
        $display("covered %0d bytes in %0d messages, %0d chars checked, %0d register writes",
                 n_bytes, n_msgs, n_chars, n_cfg);
        $display("key lengths 0 to 15, all padding cases, position wrap and output stalls");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
rtl/core/kxb_pkg.sv
rtl/core/kxb_front.sv
rtl/core/kxb_queue.sv
rtl/core/kxb_back.sv
rtl/core/keyed_xor_base64_encoder.sv
sim/keyed_xor_base64_encoder_tb.sv
